// ===== rtl/fqr_pkg.sv =====
// Package for the linked-list ready queue: field widths, operation and
// status codes, parameter defaults and the result record.
// No dependencies; fqr_ctrl and the top level import it.
package fqr_pkg;

    // Field widths of the stream payload.
    localparam int HANDLE_W = 16;
    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;

    // Parameter defaults for the top level.
    localparam int DEF_QUEUE_DEPTH = 64;
    localparam int DEF_HANDLE_BITS = 16;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd2;
    localparam logic [OP_W-1:0] OP_CRESET = 3'd3;
    localparam logic [OP_W-1:0] OP_CNEXT  = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] ST_MISS  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd3;

    // One result handed from the sequencer to the output stage.
    typedef struct packed {
        logic [HANDLE_W-1:0] handle;
        logic [STATUS_W-1:0] status;
        logic                is_empty;
        logic                cursor_at_end;
    } t_result;

endpackage

// ===== rtl/fqr_ram.sv =====
// Simple dual-port synchronous RAM: one write port, one registered read port.
// A read and a write to the same address in one cycle return the old data.
// Depends on nothing.
module fqr_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and read-first registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/fqr_ctrl.sv =====
// Operation sequencer of the ready queue: holds head, tail, free, cursor,
// count and fill pointers and drives the handle and link memories.
// Depends on fqr_pkg.
module fqr_ctrl #(
    parameter int QUEUE_DEPTH = fqr_pkg::DEF_QUEUE_DEPTH,
    parameter int HANDLE_BITS = fqr_pkg::DEF_HANDLE_BITS,
    localparam int LW = $clog2(QUEUE_DEPTH + 1),
    localparam int IW = $clog2(QUEUE_DEPTH),
    localparam int HW = (HANDLE_BITS < fqr_pkg::HANDLE_W) ? HANDLE_BITS : fqr_pkg::HANDLE_W
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Operation request.
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [fqr_pkg::OP_W-1:0]      i_op,
    input  logic [fqr_pkg::HANDLE_W-1:0]  i_handle,
    // Result hand-off.
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output fqr_pkg::t_result              o_res,
    // Memory ports.
    output logic [IW-1:0]                 o_rd_addr,
    input  logic [LW-1:0]                 i_rd_link,
    input  logic [HW-1:0]                 i_rd_handle,
    output logic                          o_link_we,
    output logic [IW-1:0]                 o_link_waddr,
    output logic [LW-1:0]                 o_link_wdata,
    output logic                          o_hnd_we,
    output logic [IW-1:0]                 o_hnd_waddr,
    output logic [HW-1:0]                 o_hnd_wdata
);
    import fqr_pkg::*;

    localparam logic [LW-1:0] NIL   = LW'(QUEUE_DEPTH);
    localparam logic [LW-1:0] ONE_L = LW'(1);

    typedef enum logic [2:0] {
        S_IDLE, S_START, S_PUSH, S_POP, S_SRCH, S_FIXPREV, S_NEXT, S_DONE
    } t_state;

    t_state              r_state;
    logic [LW-1:0]       r_head, r_tail, r_free, r_cursor, r_count, r_fill;
    logic [OP_W-1:0]     r_op;
    logic [HW-1:0]       r_hnd;
    logic [LW-1:0]       r_e, r_prev, r_nxt;
    logic [HW-1:0]       r_rhnd;
    logic [STATUS_W-1:0] r_status;

    logic full;
    logic match;

    assign full  = (r_count >= NIL) || (r_free == NIL);
    assign match = (i_rd_handle == r_hnd);

    // Memory addressing and write-back for each step of an operation.
    always_comb begin
        o_rd_addr    = r_e[IW-1:0];
        o_link_we    = 1'b0;
        o_link_waddr = r_e[IW-1:0];
        o_link_wdata = NIL;
        o_hnd_we     = 1'b0;
        o_hnd_waddr  = r_free[IW-1:0];
        o_hnd_wdata  = r_hnd;
        unique case (r_state)
            S_START: begin
                unique case (r_op)
                    OP_PUSH: begin
                        o_rd_addr = r_free[IW-1:0];
                        if (!full) begin
                            o_hnd_we     = 1'b1;
                            o_link_we    = 1'b1;
                            o_link_waddr = r_free[IW-1:0];
                            o_link_wdata = NIL;
                        end
                    end
                    OP_POP, OP_REMOVE: o_rd_addr = r_head[IW-1:0];
                    OP_CNEXT:          o_rd_addr = r_cursor[IW-1:0];
                    default: ;
                endcase
            end
            S_PUSH: begin
                if (r_tail != NIL) begin
                    o_link_we    = 1'b1;
                    o_link_waddr = r_tail[IW-1:0];
                    o_link_wdata = r_free;
                end
            end
            S_POP: begin
                o_link_we    = 1'b1;
                o_link_waddr = r_e[IW-1:0];
                o_link_wdata = r_free;
            end
            S_SRCH: begin
                if (match) begin
                    o_link_we    = 1'b1;
                    o_link_waddr = r_e[IW-1:0];
                    o_link_wdata = r_free;
                end else begin
                    o_rd_addr = i_rd_link[IW-1:0];
                end
            end
            S_FIXPREV: begin
                o_link_we    = 1'b1;
                o_link_waddr = r_prev[IW-1:0];
                o_link_wdata = r_nxt;
            end
            default: ;
        endcase
    end

    // Sequencer state, queue pointers and the held result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= NIL;
            r_tail   <= NIL;
            r_cursor <= NIL;
            r_free   <= '0;
            r_count  <= '0;
            r_fill   <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_op    <= i_op;
                        r_hnd   <= i_handle[HW-1:0];
                        r_state <= S_START;
                    end
                end
                S_START: begin
                    r_rhnd <= '0;
                    unique case (r_op)
                        OP_PUSH: begin
                            if (full) begin
                                r_status <= ST_FULL;
                                r_state  <= S_DONE;
                            end else begin
                                r_status <= ST_OK;
                                r_state  <= S_PUSH;
                            end
                        end
                        OP_POP: begin
                            if (r_head == NIL) begin
                                r_status <= ST_EMPTY;
                                r_state  <= S_DONE;
                            end else begin
                                r_status <= ST_OK;
                                r_e      <= r_head;
                                r_state  <= S_POP;
                            end
                        end
                        OP_REMOVE: begin
                            if (r_head == NIL) begin
                                r_status <= ST_EMPTY;
                                r_state  <= S_DONE;
                            end else begin
                                r_status <= ST_OK;
                                r_e      <= r_head;
                                r_prev   <= NIL;
                                r_state  <= S_SRCH;
                            end
                        end
                        OP_CRESET: begin
                            r_status <= ST_OK;
                            r_cursor <= r_head;
                            r_state  <= S_DONE;
                        end
                        OP_CNEXT: begin
                            if (r_cursor == NIL) begin
                                r_status <= ST_MISS;
                                r_state  <= S_DONE;
                            end else begin
                                r_status <= ST_OK;
                                r_state  <= S_NEXT;
                            end
                        end
                        default: begin
                            r_status <= ST_OK;
                            r_state  <= S_DONE;
                        end
                    endcase
                end
                S_PUSH: begin
                    // Entries at and above the fill mark were never used and
                    // chain to their neighbor without a memory read.
                    if (r_free == r_fill) begin
                        r_free <= r_fill + ONE_L;
                        r_fill <= r_fill + ONE_L;
                    end else begin
                        r_free <= i_rd_link;
                    end
                    if (r_tail == NIL) begin
                        r_head <= r_free;
                    end
                    r_tail  <= r_free;
                    r_count <= r_count + ONE_L;
                    r_state <= S_DONE;
                end
                S_POP: begin
                    r_rhnd <= i_rd_handle;
                    r_head <= i_rd_link;
                    if (r_tail == r_e) begin
                        r_tail <= NIL;
                    end
                    if (r_cursor == r_e) begin
                        r_cursor <= i_rd_link;
                    end
                    r_free  <= r_e;
                    r_count <= r_count - ONE_L;
                    r_state <= S_DONE;
                end
                S_SRCH: begin
                    if (match) begin
                        r_rhnd <= i_rd_handle;
                        if (r_prev == NIL) begin
                            r_head <= i_rd_link;
                        end
                        if (r_tail == r_e) begin
                            r_tail <= r_prev;
                        end
                        if (r_cursor == r_e) begin
                            r_cursor <= i_rd_link;
                        end
                        r_free  <= r_e;
                        r_count <= r_count - ONE_L;
                        r_nxt   <= i_rd_link;
                        r_state <= (r_prev == NIL) ? S_DONE : S_FIXPREV;
                    end else if (i_rd_link == NIL) begin
                        r_status <= ST_MISS;
                        r_state  <= S_DONE;
                    end else begin
                        // Step to the successor; its read was issued this cycle.
                        r_prev <= r_e;
                        r_e    <= i_rd_link;
                    end
                end
                S_FIXPREV: r_state <= S_DONE;
                S_NEXT: begin
                    r_rhnd   <= i_rd_handle;
                    r_cursor <= i_rd_link;
                    r_state  <= S_DONE;
                end
                S_DONE: begin
                    if (i_res_ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Flags reflect the pointers as they stand once the operation is finished.
    assign o_in_ready           = (r_state == S_IDLE);
    assign o_res_valid          = (r_state == S_DONE);
    assign o_res.handle         = HANDLE_W'(r_rhnd);
    assign o_res.status         = r_status;
    assign o_res.is_empty       = (r_head == NIL);
    assign o_res.cursor_at_end  = (r_cursor == NIL);

endmodule

// ===== rtl/fifo_queue_with_removal.sv =====
// Top level of the linked-list ready queue: sequencer, handle and link
// memories, and the output register of the result stream.
// Depends on fqr_pkg, fqr_ram and fqr_ctrl.
//
// Ready queue of task handles kept in arrival order as a linked list in two
// synchronous memories (handles and next links), with a free list of unused
// entries. Each transfer on the input stream carries one operation in tuser
// (push, pop head, remove first matching handle, cursor reset, cursor next)
// and a handle in tdata; each produces exactly one result transfer with the
// handle involved, a status code, the empty flag and the cursor-at-end flag.
// Push, pop and cursor next register the request, read the memory, then
// write back (push, pop) or take the entry read (cursor next), and hand the
// result to the output register. Cursor reset, the unused operation codes,
// a refused push and a pop, remove or cursor next on an empty queue or at
// the end skip the memory step. Remove reads one entry at a time until the
// match, then rewrites the link of the match's predecessor if it has one;
// a remove that finds no match walks past every entry in the queue. The
// walk is bound by the read latency of the link memory. A result waiting in
// the output register does not stop the next operation from being accepted,
// but that operation holds its result and the input until the register
// drains. There is no clearing pass after reset: a fill mark tracks entries
// never taken from the free list.
module fifo_queue_with_removal #(
    parameter int QUEUE_DEPTH = fqr_pkg::DEF_QUEUE_DEPTH,
    parameter int HANDLE_BITS = fqr_pkg::DEF_HANDLE_BITS
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // Input stream.
    input  logic                         i_s_tvalid,
    output logic                         o_s_tready,
    input  logic [15:0]                  i_s_tdata,  // [15:0] item_handle
    input  logic [7:0]                   i_s_tuser,  // [2:0] operation
    // Output stream.
    output logic                         o_m_tvalid,
    input  logic                         i_m_tready,
    output logic [15:0]                  o_m_tdata,  // [15:0] result_handle
    output logic [7:0]                   o_m_tuser   // [1:0] status, [2] is_empty,
                                                     // [3] cursor_at_end
);
    import fqr_pkg::*;

    localparam int LW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = $clog2(QUEUE_DEPTH);
    localparam int HW = (HANDLE_BITS < HANDLE_W) ? HANDLE_BITS : HANDLE_W;

    logic          res_valid, res_ready;
    t_result       res;
    logic [IW-1:0] rd_addr;
    logic [LW-1:0] rd_link;
    logic [HW-1:0] rd_handle;
    logic          link_we, hnd_we;
    logic [IW-1:0] link_waddr, hnd_waddr;
    logic [LW-1:0] link_wdata;
    logic [HW-1:0] hnd_wdata;

    logic          r_out_valid;
    t_result       r_out;

    // Operation sequencer.
    fqr_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .HANDLE_BITS (HANDLE_BITS)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_s_tvalid),
        .o_in_ready   (o_s_tready),
        .i_op         (i_s_tuser[OP_W-1:0]),
        .i_handle     (i_s_tdata),
        .o_res_valid  (res_valid),
        .i_res_ready  (res_ready),
        .o_res        (res),
        .o_rd_addr    (rd_addr),
        .i_rd_link    (rd_link),
        .i_rd_handle  (rd_handle),
        .o_link_we    (link_we),
        .o_link_waddr (link_waddr),
        .o_link_wdata (link_wdata),
        .o_hnd_we     (hnd_we),
        .o_hnd_waddr  (hnd_waddr),
        .o_hnd_wdata  (hnd_wdata)
    );

    // Next-link memory.
    fqr_ram #(
        .WIDTH (LW),
        .DEPTH (QUEUE_DEPTH)
    ) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_link)
    );

    // Handle memory.
    fqr_ram #(
        .WIDTH (HW),
        .DEPTH (QUEUE_DEPTH)
    ) u_hnd_ram (
        .i_clk   (i_clk),
        .i_we    (hnd_we),
        .i_waddr (hnd_waddr),
        .i_wdata (hnd_wdata),
        .i_raddr (rd_addr),
        .o_rdata (rd_handle)
    );

    // Output register: takes a result whenever it is empty or being drained.
    assign res_ready = !r_out_valid || i_m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res_ready) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_out <= res;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out.handle;
    assign o_m_tuser  = {4'b0000, r_out.cursor_at_end, r_out.is_empty, r_out.status};

endmodule
